/* rtl/apmg_pkg.sv */
package apmg_pkg;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 20;

  typedef enum logic [CfgAddrW-1:0] {
    RegDeviationLimit = 1'b0,
    RegErrorRate      = 1'b1
  } cfg_reg_e;

  localparam int unsigned DevW  = 20;
  localparam int unsigned RateW = 17;
  // fraction bits of the Q1.16 error_rate
  localparam int unsigned RateFracW = 16;

  localparam int unsigned GradeW = 3;

  typedef enum logic [GradeW-1:0] {
    GradeMismatch  = 3'd0,
    GradeGood      = 3'd1,
    GradeSkip      = 3'd2,
    GradeExcellent = 3'd3,
    GradeAmazing   = 3'd4
  } grade_e;

endpackage

/* rtl/apmg_coord_check.sv */
module apmg_coord_check #(
  parameter int unsigned PosW = 32
) (
  input  logic signed [PosW-1:0]           p_i,
  input  logic signed [PosW-1:0]           q_i,
  input  logic signed [PosW-1:0]           d_i,
  input  logic [apmg_pkg::DevW-1:0]        dev_i,
  input  logic [apmg_pkg::RateW-1:0]       rate_i,
  output logic                             pass_o
);

  localparam int unsigned ProdW = PosW + apmg_pkg::RateW;
  localparam int unsigned CmpW  = PosW + 2 + apmg_pkg::DevW;

  logic signed [PosW:0]   shifted;
  logic signed [PosW+1:0] off_diff;
  logic [PosW+1:0]        off_mag;
  logic signed [PosW:0]   span;
  logic signed [PosW+1:0] ratio_diff;
  logic [PosW+1:0]        ratio_mag;
  logic [PosW-1:0]        step_mag;
  logic [ProdW-1:0]       prod;
  logic [PosW:0]          limit;
  logic                   offset_ok;
  logic                   ratio_ok;

  // Offset test: first position moved by the step lands near the second
  always_comb begin
    shifted   = {p_i[PosW-1], p_i} + {d_i[PosW-1], d_i};
    off_diff  = {shifted[PosW], shifted} - {{2{q_i[PosW-1]}}, q_i};
    off_mag   = off_diff[PosW+1] ? (PosW+2)'(-off_diff) : off_diff;
    offset_ok = (p_i != '0) && (q_i != '0) && (shifted != '0) &&
                (CmpW'(off_mag) <= CmpW'(dev_i));
  end

  // Ratio test: |d - (q - p)| <= (|d| * rate) >> 16, never for a zero step
  always_comb begin
    span       = {q_i[PosW-1], q_i} - {p_i[PosW-1], p_i};
    ratio_diff = {{2{d_i[PosW-1]}}, d_i} - {span[PosW], span};
    ratio_mag  = ratio_diff[PosW+1] ? (PosW+2)'(-ratio_diff) : ratio_diff;
    step_mag   = d_i[PosW-1] ? PosW'(-d_i) : d_i;
    prod       = ProdW'(step_mag) * ProdW'(rate_i);
    limit      = prod[ProdW-1:apmg_pkg::RateFracW];
    ratio_ok   = (d_i != '0) && (ratio_mag <= {1'b0, limit});
  end

  assign pass_o = offset_ok || ratio_ok;

endmodule

/* rtl/anchor_pair_match_grader_unit.sv */
// Channel   Dir  Word                                        Handshake
// s_axis    in   tdata: query_pos_a, ref_pos_a, query_pos_b,  tvalid/tready
//                ref_pos_b, edge_step (POS_WIDTH bits each)
// m_axis    out  tdata: grade (3 bits)                        tvalid/tready
// cfg       in   cfg_addr_i: register, cfg_data_i: value      cfg_valid_i/cfg_ready_o
//
// An accepted input word passes through one input register, then the offset and
// ratio tests, each coordinate check with its own |edge_step| x error_rate multiply,
// then the result register, before its grade appears on m_axis.
// One word per cycle is sustained; s_axis stalls only while both stages are full
// and m_axis_tready is low. Reset clears the valid flags and both configuration
// registers to 0.
module anchor_pair_match_grader_unit #(
  parameter int unsigned POS_WIDTH = 32,
  localparam int unsigned InDataW  = ((5 * POS_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((apmg_pkg::GradeW + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // query_pos_a, ref_pos_a, query_pos_b, ref_pos_b, edge_step, zero pad
  input  logic [InDataW-1:0]                s_axis_tdata,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // grade, zero pad
  output logic [OutDataW-1:0]               m_axis_tdata,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [apmg_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [apmg_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned W = POS_WIDTH;

  logic [apmg_pkg::DevW-1:0]  dev_q;
  logic [apmg_pkg::RateW-1:0] rate_q;

  logic                       in_vld_q;
  logic signed [W-1:0]        qa_q, ra_q, qb_q, rb_q, step_q;
  logic                       out_vld_q;
  apmg_pkg::grade_e           grade_q, grade_d;

  logic                       out_adv;
  logic                       in_adv;
  logic                       q_pass, r_pass;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q  <= '0;
      rate_q <= '0;
    end else if (cfg_valid_i) begin
      case (apmg_pkg::cfg_reg_e'(cfg_addr_i))
        apmg_pkg::RegDeviationLimit: dev_q  <= cfg_data_i[apmg_pkg::DevW-1:0];
        apmg_pkg::RegErrorRate:      rate_q <= cfg_data_i[apmg_pkg::RateW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  assign out_adv       = !out_vld_q || m_axis_tready;
  assign in_adv        = !in_vld_q || out_adv;
  assign s_axis_tready = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) in_vld_q <= s_axis_tvalid;
      if (out_adv) out_vld_q <= in_vld_q;
    end
  end

  // Input word register
  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) begin
      qa_q   <= s_axis_tdata[0*W +: W];
      ra_q   <= s_axis_tdata[1*W +: W];
      qb_q   <= s_axis_tdata[2*W +: W];
      rb_q   <= s_axis_tdata[3*W +: W];
      step_q <= s_axis_tdata[4*W +: W];
    end
  end

  apmg_coord_check #(.PosW(W)) u_query_check (
    .p_i    (qa_q),
    .q_i    (qb_q),
    .d_i    (step_q),
    .dev_i  (dev_q),
    .rate_i (rate_q),
    .pass_o (q_pass)
  );

  apmg_coord_check #(.PosW(W)) u_ref_check (
    .p_i    (ra_q),
    .q_i    (rb_q),
    .d_i    (step_q),
    .dev_i  (dev_q),
    .rate_i (rate_q),
    .pass_o (r_pass)
  );

  // Grade selection by the pattern of absent positions
  always_comb begin
    grade_d = apmg_pkg::GradeMismatch;
    if (qa_q == '0 || qb_q == '0) begin
      if (r_pass) begin
        if (qb_q != '0)      grade_d = apmg_pkg::GradeExcellent;
        else if (qa_q != '0) grade_d = apmg_pkg::GradeSkip;
        else                 grade_d = apmg_pkg::GradeGood;
      end
    end else if (ra_q == '0 || rb_q == '0) begin
      if (q_pass) begin
        grade_d = (rb_q != '0) ? apmg_pkg::GradeExcellent : apmg_pkg::GradeGood;
      end
    end else begin
      if (q_pass && r_pass) grade_d = apmg_pkg::GradeAmazing;
      else if (q_pass)      grade_d = apmg_pkg::GradeExcellent;
      else if (r_pass)      grade_d = apmg_pkg::GradeSkip;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_adv && in_vld_q) begin
      grade_q <= grade_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutDataW'(grade_q);

  // Checks
  a_word_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_adv) |=> m_axis_tvalid)
    else $error("buffered word did not reach the result register");

  a_no_query_grade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_adv && qa_q == '0 && qb_q == '0) |=>
      (grade_q == apmg_pkg::GradeMismatch || grade_q == apmg_pkg::GradeGood))
    else $error("grade with both query positions absent out of range");

  a_dev_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_addr_i == apmg_pkg::RegDeviationLimit) |=>
      (dev_q == $past(cfg_data_i[apmg_pkg::DevW-1:0])))
    else $error("deviation limit write lost");

  a_input_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while both stages are full");

endmodule

/* sim/tb_anchor_pair_match_grader_unit.sv */
`timescale 1ns / 100ps

module tb_anchor_pair_match_grader_unit;

  localparam int unsigned PosW       = 32;
  localparam int unsigned InW        = 5 * PosW;
  localparam int          CycleLimit = 300_000;
  localparam int          PhaseItems = 140;
  localparam int          NumPhases  = 6;

  typedef struct {
    logic [PosW-1:0]  qa;
    logic [PosW-1:0]  ra;
    logic [PosW-1:0]  qb;
    logic [PosW-1:0]  rb;
    logic [PosW-1:0]  step;
    bit               typed;
    apmg_pkg::grade_e grade;
  } pair_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // query_pos_a, ref_pos_a, query_pos_b, ref_pos_b, edge_step
  logic [InW-1:0]    s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // grade, zero pad
  logic [7:0]        m_axis_tdata;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [apmg_pkg::CfgAddrW-1:0] cfg_addr_i = '0;
  logic [apmg_pkg::CfgDataW-1:0] cfg_data_i = '0;

  // register copies used by the grade predictor
  logic [apmg_pkg::DevW-1:0]  dev_now = '0;
  logic [apmg_pkg::RateW-1:0] rate_now = '0;

  apmg_pkg::grade_e  grades_due[$];
  apmg_pkg::grade_e  want_grade;
  pair_row_t         hit_rows[$];
  bit                idle_on = 1'b1;
  int                errors = 0;
  int                items_sent = 0;
  int                grades_checked = 0;
  int                graded[5] = '{default: 0};
  int                cycle_count = 0;

  anchor_pair_match_grader_unit #(
    .POS_WIDTH(PosW)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d grades outstanding", cycle_count,
               grades_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // offset test or ratio test on one coordinate, exact in 64 bits
  function automatic logic coord_pass(logic signed [PosW-1:0] p, logic signed [PosW-1:0] q,
                                      logic signed [PosW-1:0] d);
    longint sp, sq, sd, shifted;
    logic   off_ok, ratio_ok;
    sp = p;
    sq = q;
    sd = d;
    shifted = sp + sd;
    off_ok = (sp != 0) && (sq != 0) && (shifted != 0) &&
             (mag(shifted - sq) <= longint'(dev_now));
    ratio_ok = (sd != 0) &&
               (mag(sd - (sq - sp)) * 65536 <= mag(sd) * longint'(rate_now));
    return off_ok || ratio_ok;
  endfunction

  function automatic apmg_pkg::grade_e grade_of_pair(logic [InW-1:0] w);
    logic signed [PosW-1:0] qa, ra, qb, rb, d;
    logic                   fq, fr;
    qa = w[0*PosW +: PosW];
    ra = w[1*PosW +: PosW];
    qb = w[2*PosW +: PosW];
    rb = w[3*PosW +: PosW];
    d  = w[4*PosW +: PosW];
    fq = coord_pass(qa, qb, d);
    fr = coord_pass(ra, rb, d);
    if (qa == 0 || qb == 0) begin
      if (!fr) return apmg_pkg::GradeMismatch;
      return (qb != 0) ? apmg_pkg::GradeExcellent
                       : ((qa != 0) ? apmg_pkg::GradeSkip : apmg_pkg::GradeGood);
    end
    if (ra == 0 || rb == 0) begin
      if (!fq) return apmg_pkg::GradeMismatch;
      return (rb != 0) ? apmg_pkg::GradeExcellent : apmg_pkg::GradeGood;
    end
    if (fq && fr) return apmg_pkg::GradeAmazing;
    if (fq) return apmg_pkg::GradeExcellent;
    if (fr) return apmg_pkg::GradeSkip;
    return apmg_pkg::GradeMismatch;
  endfunction

  function automatic void add_row(logic [PosW-1:0] qa, logic [PosW-1:0] ra,
                                  logic [PosW-1:0] qb, logic [PosW-1:0] rb,
                                  logic [PosW-1:0] step, bit typed, apmg_pkg::grade_e g);
    pair_row_t r;
    r.qa = qa;
    r.ra = ra;
    r.qb = qb;
    r.rb = rb;
    r.step = step;
    r.typed = typed;
    r.grade = g;
    hit_rows.insert(hit_rows.size(), r);
  endfunction

  function automatic logic [PosW-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      2, 3: return $urandom;
      default: return $urandom_range(0, 1) ? -$urandom_range(1, 1_000_000)
                                            : $urandom_range(1, 1_000_000);
    endcase
  endfunction

  function automatic logic [PosW-1:0] pick_step();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(0, 1) ? -$urandom_range(1, 5000)
                                            : $urandom_range(1, 5000);
    endcase
  endfunction

  // second position near first + step, straddling the offset and ratio limits, or random or zero
  function automatic logic [PosW-1:0] pick_second(logic signed [PosW-1:0] p,
                                                  logic signed [PosW-1:0] d);
    longint sp, sd, lim, nudge;
    sp = p;
    sd = d;
    lim = (mag(sd) * longint'(rate_now)) >>> 16;
    case ($urandom_range(0, 7))
      0: nudge = 0;
      1: nudge = $urandom_range(0, dev_now);
      2: nudge = longint'(dev_now) + 1;
      3: nudge = lim;
      4: nudge = lim + 1;
      5: nudge = $urandom_range(0, 50);
      6: return $urandom;
      default: return '0;
    endcase
    if ($urandom_range(0, 1)) nudge = -nudge;
    return PosW'(sp + sd + nudge);
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // hold the word until accepted, then maybe drop valid for a burst
  task automatic send_word(logic [InW-1:0] w, apmg_pkg::grade_e g);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    grades_due.insert(grades_due.size(), g);
    items_sent++;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(apmg_pkg::cfg_reg_e idx, logic [apmg_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == apmg_pkg::RegDeviationLimit) dev_now = val[apmg_pkg::DevW-1:0];
    else rate_now = val[apmg_pkg::RateW-1:0];
  endtask

  task automatic drain();
    while (grades_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver: stall in bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (grades_due.size() == 0) begin
        flag_mismatch($sformatf("grade %0d with none expected",
                                m_axis_tdata[apmg_pkg::GradeW-1:0]));
      end else begin
        want_grade = grades_due.pop_front();
        grades_checked++;
        graded[want_grade]++;
        if (m_axis_tdata[apmg_pkg::GradeW-1:0] !== want_grade)
          flag_mismatch($sformatf("grade %0d, expected %0d (%s)",
                                  m_axis_tdata[apmg_pkg::GradeW-1:0],
                                  want_grade, want_grade.name()));
      end
    end
  end

  initial begin
    logic [apmg_pkg::CfgDataW-1:0] dev_plan[NumPhases];
    logic [apmg_pkg::CfgDataW-1:0] rate_plan[NumPhases];
    logic [PosW-1:0]               qa, ra, qb, rb, d;
    logic [InW-1:0]                w;

    dev_plan  = '{20'h0_0000, 20'hF_FFFF, 20'h0_0011, 20'h0_0000, 20'h0_0000, 20'h0_0003};
    // upper bits of the rate writes above bit 16 must be dropped
    rate_plan = '{20'h1_0000, 20'h0_0000, 20'hE_199A, 20'h1_FFFF, 20'h0_0000, 20'h0_0CCD};
    dev_plan[3]  = $urandom_range(0, 4095);
    dev_plan[4]  = $urandom_range(0, 1_048_575);
    rate_plan[4] = $urandom_range(0, 70_000);

    // registers at reset: no deviation, no ratio slack
    add_row('0, '0, '0, '0, '0, 1, apmg_pkg::GradeMismatch);
    add_row(10, 0, 20, 0, 10, 1, apmg_pkg::GradeGood);
    add_row(10, 100, 20, 110, 10, 1, apmg_pkg::GradeAmazing);
    add_row(10, 100, 20, 200, 10, 1, apmg_pkg::GradeExcellent);
    add_row(10, 100, 30, 110, 10, 1, apmg_pkg::GradeSkip);
    add_row(10, 100, 30, 200, 10, 1, apmg_pkg::GradeMismatch);
    add_row(0, 100, 20, 110, 10, 1, apmg_pkg::GradeExcellent);
    add_row(5, 100, 0, 110, 10, 1, apmg_pkg::GradeSkip);
    add_row(0, 100, 0, 110, 10, 1, apmg_pkg::GradeGood);
    add_row(10, 0, 20, 110, 10, 1, apmg_pkg::GradeExcellent);
    // zero step: ratio test fails
    add_row(10, 0, 11, 0, 0, 1, apmg_pkg::GradeMismatch);
    add_row(10, 0, 10, 0, 0, 0, apmg_pkg::GradeMismatch);
    // shifted position must not wrap
    add_row(32'h7FFF_FFFF, 0, 32'hFFFF_FFFE, 0, 32'h7FFF_FFFF, 1, apmg_pkg::GradeMismatch);
    // shifted position lands on zero
    add_row(5, 0, 3, 0, 32'hFFFF_FFFB, 0, apmg_pkg::GradeMismatch);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
            apmg_pkg::GradeMismatch);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
            apmg_pkg::GradeMismatch);
    add_row(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 0, 0, apmg_pkg::GradeMismatch);
    add_row(100, 32'hFFFF_FF00, 90, 32'hFFFF_FEF6, 32'hFFFF_FFF6, 0,
            apmg_pkg::GradeMismatch);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
            apmg_pkg::GradeMismatch);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (hit_rows[i]) begin
      w = {hit_rows[i].step, hit_rows[i].rb, hit_rows[i].qb, hit_rows[i].ra, hit_rows[i].qa};
      send_word(w, hit_rows[i].typed ? hit_rows[i].grade : grade_of_pair(w));
    end
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      // sender waits here until every grade is back
      drain();
      write_reg(apmg_pkg::RegDeviationLimit, dev_plan[ph]);
      write_reg(apmg_pkg::RegErrorRate, rate_plan[ph]);
      cfg_valid_i <= 1'b0;
      idle_on = (ph != NumPhases - 1);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          w = {$urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
          d  = pick_step();
          qa = pick_pos();
          ra = pick_pos();
          qb = pick_second(qa, d);
          rb = pick_second(ra, d);
          w  = {d, rb, qb, ra, qa};
        end
        send_word(w, grade_of_pair(w));
      end
      s_axis_tvalid <= 1'b0;
    end

    while (grades_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d words sent across reset and %0d register settings, %0d grades checked",
             items_sent, NumPhases, grades_checked);
    $display("grades: mismatch %0d, good %0d, skip %0d, excellent %0d, amazing %0d",
             graded[apmg_pkg::GradeMismatch], graded[apmg_pkg::GradeGood],
             graded[apmg_pkg::GradeSkip], graded[apmg_pkg::GradeExcellent],
             graded[apmg_pkg::GradeAmazing]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
